### hdl/ers_pkg.sv
// ers_pkg: shared types and constants for the euclidean rating similarity block.
// Holds field widths, the command/status structs between controller and datapath,
// and the rating clamp. No dependencies.
package ers_pkg;

    localparam int unsigned USER_W     = 16;
    localparam int unsigned RATING_W   = 4;
    localparam int unsigned SIM_W      = 17;
    localparam int unsigned SUM_W      = 19;
    localparam int unsigned CNT_W      = 13;
    localparam int unsigned BIT_W      = 5;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 72;
    localparam int unsigned ADDR_W     = 2;

    localparam int unsigned RATING_STEPS = 10;

    localparam logic [SUM_W-1:0]  SUM_MAX     = 19'h7FFFF;
    localparam logic [CNT_W-1:0]  CNT_MAX     = 13'h1FFF;
    localparam logic [BIT_W-1:0]  Q_TOP_BIT   = 5'd16;
    localparam logic [SIM_W:0]    ONE_TWO_Q16 = 18'd131072;
    localparam logic [SIM_W-1:0]  SIM_ONE     = 17'd65536;
    localparam logic [ADDR_W-1:0] ADDR_MODE   = 2'd0;

    // Operand selection of the shared multiplier
    typedef enum logic [1:0] {
        MUL_SQ,
        MUL_REST,
        MUL_LO,
        MUL_HI
    } t_mul_op;

    typedef struct packed {
        logic             accum;
        logic             clear_q;
        logic             mul_en;
        t_mul_op          mul_op;
        logic             cmp_en;
        logic [BIT_W-1:0] bit_idx;
        logic             load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_nz;
        logic out_free;
    } t_dp_sts;

    // Ratings above the scale are taken as the top rating
    function automatic logic [RATING_W-1:0] clamp_rating(input logic [RATING_W-1:0] r);
        logic [RATING_W-1:0] top;
        top = RATING_W'(RATING_STEPS);
        clamp_rating = (r > top) ? top : r;
    endfunction

endpackage

### hdl/ers_dp.sv
// ers_dp: datapath of the similarity block.
// Accumulators, the shared 17x19 multiplier, the bit-serial quotient search
// and the output register. Uses ers_pkg.
module ers_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ers_pkg::t_dp_cmd                   i_cmd,
    output ers_pkg::t_dp_sts                   o_sts,
    input  logic                               i_mode,
    input  logic [ers_pkg::IN_DATA_W-1:0]      i_s_data,
    input  logic                               i_s_last,
    input  logic                               i_m_ready,
    output logic                               o_m_valid,
    output logic [ers_pkg::OUT_DATA_W-1:0]     o_m_data,
    output logic                               o_m_user
);

    logic [ers_pkg::SUM_W-1:0]    r_sum;
    logic [ers_pkg::CNT_W-1:0]    r_cnt;
    logic [ers_pkg::USER_W-1:0]   r_user_a;
    logic [ers_pkg::USER_W-1:0]   r_user_b;
    logic [ers_pkg::SIM_W-1:0]    r_q;
    logic [33:0]                  r_tsq;
    logic [33:0]                  r_rest2;
    logic [35:0]                  r_plo;
    logic [35:0]                  r_phi;
    logic                         r_m_valid;
    logic [ers_pkg::OUT_DATA_W-1:0] r_m_data;
    logic                         r_m_user;

    logic [ers_pkg::RATING_W-1:0] rate_a;
    logic [ers_pkg::RATING_W-1:0] rate_b;
    logic                         counts;
    logic [ers_pkg::RATING_W-1:0] diff;
    logic [6:0]                   diff_sq;
    logic [ers_pkg::SUM_W:0]      sum_wide;
    logic [ers_pkg::SUM_W-1:0]    n_sum;
    logic [ers_pkg::CNT_W-1:0]    n_cnt;

    logic [ers_pkg::SIM_W-1:0]    trial;
    logic                         range_ok;
    logic [ers_pkg::SIM_W:0]      rest_full;
    logic [ers_pkg::SIM_W-1:0]    rest;
    logic [16:0]                  mul_a;
    logic [18:0]                  mul_b;
    logic [35:0]                  product;
    logic [53:0]                  lhs;
    logic                         fits;
    logic [ers_pkg::SIM_W-1:0]    sim_out;

    // Per-word accumulate step
    always_comb begin
        rate_a   = ers_pkg::clamp_rating(i_s_data[35:32]);
        rate_b   = ers_pkg::clamp_rating(i_s_data[39:36]);
        counts   = i_mode ? ((rate_a != '0) && (rate_b != '0))
                          : ((rate_a != '0) || (rate_b != '0));
        diff     = (rate_a > rate_b) ? (rate_a - rate_b) : (rate_b - rate_a);
        diff_sq  = {3'b000, diff} * {3'b000, diff};
        sum_wide = {1'b0, r_sum} + {13'b0, diff_sq};
        n_sum    = sum_wide[ers_pkg::SUM_W] ? ers_pkg::SUM_MAX : sum_wide[ers_pkg::SUM_W-1:0];
        n_cnt    = (r_cnt == ers_pkg::CNT_MAX) ? r_cnt : (r_cnt + 1'b1);
    end

    // Trial quotient for the current bit and its range check
    always_comb begin
        trial     = r_q | (17'd1 << i_cmd.bit_idx);
        range_ok  = (trial <= ers_pkg::SIM_ONE);
        rest_full = ers_pkg::ONE_TWO_Q16 - {trial, 1'b0};
        rest      = rest_full[ers_pkg::SIM_W-1:0];
    end

    // Shared multiplier operand select
    always_comb begin
        case (i_cmd.mul_op)
            ers_pkg::MUL_SQ: begin
                mul_a = trial;
                mul_b = {2'b00, trial};
            end
            ers_pkg::MUL_REST: begin
                mul_a = rest;
                mul_b = {2'b00, rest};
            end
            ers_pkg::MUL_LO: begin
                mul_a = r_tsq[16:0];
                mul_b = r_sum;
            end
            ers_pkg::MUL_HI: begin
                mul_a = r_tsq[33:17];
                mul_b = r_sum;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        product = {19'b0, mul_a} * {17'b0, mul_b};
    end

    // q^2 * s <= (2^17 - 2q)^2 decides the bit
    always_comb begin
        lhs     = {1'b0, r_phi, 17'b0} + {18'b0, r_plo};
        fits    = range_ok && (lhs <= {20'b0, r_rest2});
        sim_out = (r_cnt != '0) ? r_q : '0;
    end

    // Control state: accumulators and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cmd.accum && counts) begin
                r_sum <= n_sum;
                r_cnt <= n_cnt;
            end else if (i_cmd.load_out) begin
                r_sum <= '0;
                r_cnt <= '0;
            end
            if (i_cmd.load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accum && i_s_last) begin
            r_user_a <= i_s_data[15:0];
            r_user_b <= i_s_data[31:16];
        end
        if (i_cmd.clear_q) begin
            r_q <= '0;
        end else if (i_cmd.cmp_en && fits) begin
            r_q <= trial;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_op)
                ers_pkg::MUL_SQ:   r_tsq   <= product[33:0];
                ers_pkg::MUL_REST: r_rest2 <= product[33:0];
                ers_pkg::MUL_LO:   r_plo   <= product;
                ers_pkg::MUL_HI:   r_phi   <= product;
                default: begin
                end
            endcase
        end
        if (i_cmd.load_out) begin
            r_m_data <= {4'b0000, r_sum, sim_out, r_user_b, r_user_a};
            r_m_user <= (r_cnt != '0);
        end
    end

    assign o_sts.cnt_nz   = (r_cnt != '0);
    assign o_sts.out_free = !r_m_valid || i_m_ready;
    assign o_m_valid      = r_m_valid;
    assign o_m_data       = r_m_data;
    assign o_m_user       = r_m_user;

endmodule

### hdl/ers_ctrl.sv
// ers_ctrl: controller state machine of the similarity block.
// Sequences accumulation, four multiplier steps and one compare per quotient
// bit, and the result hand-off. Uses ers_pkg.
module ers_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    input  logic             i_s_last,
    output logic             o_s_ready,
    input  ers_pkg::t_dp_sts i_sts,
    output ers_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_ACC,
        ST_START,
        ST_SQ,
        ST_REST,
        ST_LO,
        ST_HI,
        ST_CMP,
        ST_FIN
    } t_state;

    t_state                   r_state;
    logic [ers_pkg::BIT_W-1:0] r_bit;
    logic                     accept;

    assign o_s_ready = (r_state == ST_ACC);
    assign accept    = o_s_ready && i_s_valid;

    // State and bit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
            r_bit   <= '0;
        end else begin
            case (r_state)
                ST_ACC: begin
                    if (accept && i_s_last) begin
                        r_state <= ST_START;
                    end
                end
                ST_START: begin
                    r_bit   <= ers_pkg::Q_TOP_BIT;
                    r_state <= i_sts.cnt_nz ? ST_SQ : ST_FIN;
                end
                ST_SQ:   r_state <= ST_REST;
                ST_REST: r_state <= ST_LO;
                ST_LO:   r_state <= ST_HI;
                ST_HI:   r_state <= ST_CMP;
                ST_CMP: begin
                    if (r_bit == '0) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_bit   <= r_bit - 1'b1;
                        r_state <= ST_SQ;
                    end
                end
                ST_FIN: begin
                    if (i_sts.out_free) begin
                        r_state <= ST_ACC;
                    end
                end
                default: r_state <= ST_ACC;
            endcase
        end
    end

    // Datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.bit_idx  = r_bit;
        o_cmd.mul_op   = ers_pkg::MUL_SQ;
        case (r_state)
            ST_ACC:   o_cmd.accum   = accept;
            ST_START: o_cmd.clear_q = 1'b1;
            ST_SQ: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = ers_pkg::MUL_SQ;
            end
            ST_REST: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = ers_pkg::MUL_REST;
            end
            ST_LO: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = ers_pkg::MUL_LO;
            end
            ST_HI: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = ers_pkg::MUL_HI;
            end
            ST_CMP:   o_cmd.cmp_en   = 1'b1;
            ST_FIN:   o_cmd.load_out = i_sts.out_free;
            default: begin
            end
        endcase
    end

endmodule

### hdl/euclidean_rating_similarity.sv
// euclidean_rating_similarity: top level of the user-pair rating similarity block.
// Holds the register port and joins ers_ctrl and ers_dp; uses ers_pkg.
//
//  channel   | dir | handshake                       | word
//  s_axis    | in  | s_axis_tvalid / s_axis_tready   | two user indices, two ratings; tlast ends pair
//  m_axis    | out | m_axis_tvalid / m_axis_tready   | users, similarity, sum; tuser = valid flag
//  register  | in  | psel / penable / pwrite, pready | pair_set_mode at address 0
//
// An ordinary word is taken whenever the FSM is in the accumulate state. A last
// word with any item counted leads to a setup state, 17 quotient bits of five steps
// each on the one shared multiplier, then hand-off; with none, setup leads to hand-off.
// Synchronous active-low reset clears the accumulators, the mode and the FSM.
// While the result register is full and not taken, a finished pair waits in the
// hand-off state and no new word is accepted.
module euclidean_rating_similarity (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [15:0] first_user, [31:16] second_user, [35:32] first_rating,
    // [39:36] second_rating
    input  logic [ers_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [15:0] pair_first, [31:16] pair_second, [48:32] similarity,
    // [67:49] squared_sum, [71:68] zero
    output logic [ers_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [0] similarity_valid
    output logic [0:0]                         m_axis_tuser,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ers_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic             r_mode;
    ers_pkg::t_dp_cmd cmd;
    ers_pkg::t_dp_sts sts;
    logic             out_user;

    // Register port
    assign pready = 1'b1;
    assign prdata = (paddr == ers_pkg::ADDR_MODE) ? {31'b0, r_mode} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (psel && penable && pwrite && pready && (paddr == ers_pkg::ADDR_MODE)) begin
            r_mode <= pwdata[0];
        end
    end

    ers_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_last  (s_axis_tlast),
        .o_s_ready (s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    ers_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_mode    (r_mode),
        .i_s_data  (s_axis_tdata),
        .i_s_last  (s_axis_tlast),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_m_data  (m_axis_tdata),
        .o_m_user  (out_user)
    );

    assign m_axis_tuser = out_user;

    // No similarity without a counted item
    a_sim_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[48:32] == 17'd0))
        else $error("similarity nonzero on a pair with no counted item");

    // Similarity never exceeds one
    a_sim_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[48:32] <= 17'd65536))
        else $error("similarity above one");

    // Zero distance gives exactly one
    a_sim_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0] && (m_axis_tdata[67:49] == 19'd0))
        |-> (m_axis_tdata[48:32] == 17'd65536))
        else $error("zero sum did not give similarity one");

    // Input stalls while a finished pair is worked out
    a_stall_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("word accepted right after a last word");

endmodule
